// File: hdl/wegc_pkg.sv
// ----------------------------------------------------------------------------
// wegc_pkg
// Shared types and constants for the wheel encoder goto controller.
// ----------------------------------------------------------------------------
package wegc_pkg;

   // Default position wrap width
   localparam int ENC_WIDTH_DEF = 16;

   // Field widths fixed by the interface
   localparam int FIELD_W    = 16;
   localparam int DIFF_W     = FIELD_W + 1;
   localparam int ERR_W      = FIELD_W + 2;
   localparam int BAND_W     = 8;
   localparam int ALLOW_W    = 4;
   localparam int LEVEL_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Request codes
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_LEFT   = 3'd0,
      CSR_TARGET_RIGHT  = 3'd1,
      CSR_REACHED_BAND  = 3'd2,
      CSR_SLOW_BAND     = 3'd3,
      CSR_NORMAL_BAND   = 3'd4,
      CSR_FAST_BAND     = 3'd5,
      CSR_MAX_REVERSALS = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic signed [FIELD_W-1:0] RESET_TARGET        = '0;
   localparam logic [BAND_W-1:0]         RESET_REACHED_BAND  = 8'd2;
   localparam logic [BAND_W-1:0]         RESET_SLOW_BAND     = 8'd4;
   localparam logic [BAND_W-1:0]         RESET_NORMAL_BAND   = 8'd10;
   localparam logic [BAND_W-1:0]         RESET_FAST_BAND     = 8'd40;
   localparam logic [ALLOW_W-1:0]        RESET_MAX_REVERSALS = 4'd4;

   // Speed level codes
   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_STOP   = 3'd0,
      LEVEL_SLOW   = 3'd1,
      LEVEL_NORMAL = 3'd2,
      LEVEL_FAST   = 3'd3,
      LEVEL_MAX    = 3'd4
   } level_type;

   typedef struct packed {
      logic [BAND_W-1:0] reached;
      logic [BAND_W-1:0] slow;
      logic [BAND_W-1:0] normal;
      logic [BAND_W-1:0] fast;
   } band_cfg_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] target_left;
      logic signed [FIELD_W-1:0] target_right;
      band_cfg_type              bands;
      logic [ALLOW_W-1:0]        max_reversals;
   } cfg_type;

   // Per-wheel result and status toward the top level
   typedef struct packed {
      level_type level;
      logic      reverse;
      logic      idle_now;
      logic      idle_next;
   } wheel_stat_type;

endpackage

// File: hdl/wegc_csr.sv
// ----------------------------------------------------------------------------
// wegc_csr
// Configuration register file: decodes writes and holds the settings.
// ----------------------------------------------------------------------------
module wegc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [wegc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wegc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output wegc_pkg::cfg_type                    cfg
);

   wegc_pkg::cfg_type cfg_ff;
   wegc_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            wegc_pkg::CSR_TARGET_LEFT: begin
               cfg_in.target_left = csr_wdata;
            end
            wegc_pkg::CSR_TARGET_RIGHT: begin
               cfg_in.target_right = csr_wdata;
            end
            wegc_pkg::CSR_REACHED_BAND: begin
               cfg_in.bands.reached = csr_wdata[wegc_pkg::BAND_W-1:0];
            end
            wegc_pkg::CSR_SLOW_BAND: begin
               cfg_in.bands.slow = csr_wdata[wegc_pkg::BAND_W-1:0];
            end
            wegc_pkg::CSR_NORMAL_BAND: begin
               cfg_in.bands.normal = csr_wdata[wegc_pkg::BAND_W-1:0];
            end
            wegc_pkg::CSR_FAST_BAND: begin
               cfg_in.bands.fast = csr_wdata[wegc_pkg::BAND_W-1:0];
            end
            wegc_pkg::CSR_MAX_REVERSALS: begin
               cfg_in.max_reversals = csr_wdata[wegc_pkg::ALLOW_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_left   <= wegc_pkg::RESET_TARGET;
         cfg_ff.target_right  <= wegc_pkg::RESET_TARGET;
         cfg_ff.bands.reached <= wegc_pkg::RESET_REACHED_BAND;
         cfg_ff.bands.slow    <= wegc_pkg::RESET_SLOW_BAND;
         cfg_ff.bands.normal  <= wegc_pkg::RESET_NORMAL_BAND;
         cfg_ff.bands.fast    <= wegc_pkg::RESET_FAST_BAND;
         cfg_ff.max_reversals <= wegc_pkg::RESET_MAX_REVERSALS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/wegc_wheel.sv
// ----------------------------------------------------------------------------
// wegc_wheel
// One wheel: baseline and allowance state, error banding and direction.
// ----------------------------------------------------------------------------
module wegc_wheel #(
   parameter int ENC_WIDTH = wegc_pkg::ENC_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 start,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  enc,
   input  logic                                 dir,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  target,
   input  wegc_pkg::band_cfg_type               bands,
   input  logic [wegc_pkg::ALLOW_W-1:0]         max_reversals,
   output wegc_pkg::wheel_stat_type             stat
);

   localparam int FW    = wegc_pkg::FIELD_W;
   localparam int DW    = wegc_pkg::DIFF_W;
   localparam int EW    = wegc_pkg::ERR_W;
   localparam int AW    = wegc_pkg::ALLOW_W;
   localparam int POS_W = (ENC_WIDTH < DW) ? ENC_WIDTH : DW;

   logic [AW-1:0]          allowance_ff;
   logic [AW-1:0]          allowance_in;
   logic [FW-1:0]          baseline_ff;
   logic [FW-1:0]          baseline_in;

   logic [FW-1:0]          base_eff;
   logic [AW-1:0]          allow_cur;
   logic [DW-1:0]          diff;
   logic [POS_W-1:0]       pos_w;
   logic [EW-1:0]          pos;
   logic [EW-1:0]          err;
   logic [EW-1:0]          mag;
   logic                   err_pos;
   logic                   arrived;
   wegc_pkg::level_type    band_level;
   wegc_pkg::level_type    level;
   logic                   reverse;

   // A start item rebases and reloads before it is processed as a tick
   assign base_eff  = start ? enc : baseline_ff;
   assign allow_cur = start ? ((target != '0) ? max_reversals : '0) : allowance_ff;

   // Position wraps to ENC_WIDTH bits, capped at DIFF_W; error is exact
   assign diff  = {enc[FW-1], enc} - {base_eff[FW-1], base_eff};
   assign pos_w = diff[POS_W-1:0];
   assign pos   = {{(EW-POS_W){pos_w[POS_W-1]}}, pos_w};
   assign err   = pos - {{(EW-FW){target[FW-1]}}, target};
   assign mag   = err[EW-1] ? (~err + EW'(1)) : err;

   assign err_pos = !err[EW-1] && (err != '0);
   assign arrived = (mag <= EW'(bands.reached));

   // Band the magnitude, first match wins
   always_comb begin
      if (mag < EW'(bands.slow)) begin
         band_level = wegc_pkg::LEVEL_SLOW;
      end else if (mag < EW'(bands.normal)) begin
         band_level = wegc_pkg::LEVEL_NORMAL;
      end else if (mag < EW'(bands.fast)) begin
         band_level = wegc_pkg::LEVEL_FAST;
      end else begin
         band_level = wegc_pkg::LEVEL_MAX;
      end
   end

   // Drive command and allowance update
   always_comb begin
      level        = wegc_pkg::LEVEL_STOP;
      reverse      = 1'b0;
      allowance_in = allow_cur;
      if (allow_cur != '0) begin
         if (arrived) begin
            allowance_in = allow_cur - AW'(1);
         end else begin
            level   = band_level;
            reverse = err_pos;
            if (err_pos != dir) begin
               allowance_in = allow_cur - AW'(1);
            end
         end
      end
   end

   assign baseline_in = base_eff;

   // Commit state when the transaction moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         allowance_ff <= '0;
         baseline_ff  <= '0;
      end else if (advance) begin
         allowance_ff <= allowance_in;
         baseline_ff  <= baseline_in;
      end
   end

   assign stat.level     = level;
   assign stat.reverse   = reverse;
   assign stat.idle_now  = (allowance_ff == '0);
   assign stat.idle_next = (allowance_in == '0);

`ifndef ASSERT_OFF
   // Allowance only moves by a single step outside a start
   a_allow_step: assert property (@(posedge clock) disable iff (reset)
      advance && !start |=>
         (allowance_ff == $past(allowance_ff)) ||
         (allowance_ff == $past(allowance_ff) - AW'(1)))
      else $error("allowance changed by more than one step");

   // State holds while no transaction advances
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(allowance_ff) && $stable(baseline_ff))
      else $error("wheel state changed without an advance");
`endif

endmodule

// File: hdl/wheel_encoder_goto_controller_core.sv
// ----------------------------------------------------------------------------
// wheel_encoder_goto_controller_core
// Two-wheel drive-to-encoder-target controller with input and result stages.
// ----------------------------------------------------------------------------
//  channel   direction   handshake            payload
//  req_      in          req_valid/req_ready  type, enc left/right, dir left/right
//  rsp_      out         rsp_valid/rsp_ready  speed level/reverse per wheel, done
//  csr_      in          csr_wr_en            csr_index, csr_wdata
//
//  Response valid rises once the request has passed the input and result
//  registers; one transaction per cycle is sustained unless the response stalls.
//  Wheel state commits as a transaction moves to the result register, so the
//  next transaction sees it at once.
//  A stalled response holds both stages; the input frees when it is taken.
//  Synchronous reset clears the stage valids, wheel state and settings.
// ----------------------------------------------------------------------------
module wheel_encoder_goto_controller_core #(
   parameter int ENC_WIDTH = wegc_pkg::ENC_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  req_enc_left,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  req_enc_right,
   input  logic                                 req_dir_left,
   input  logic                                 req_dir_right,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wegc_pkg::LEVEL_W-1:0]         rsp_speed_level_left,
   output logic                                 rsp_reverse_left,
   output logic [wegc_pkg::LEVEL_W-1:0]         rsp_speed_level_right,
   output logic                                 rsp_reverse_right,
   output logic                                 rsp_run_done,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [wegc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wegc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int FW = wegc_pkg::FIELD_W;
   localparam int LW = wegc_pkg::LEVEL_W;

   wegc_pkg::cfg_type         cfg;
   wegc_pkg::wheel_stat_type  stat_left;
   wegc_pkg::wheel_stat_type  stat_right;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic                      in_type_ff;
   logic [FW-1:0]             in_enc_left_ff;
   logic [FW-1:0]             in_enc_right_ff;
   logic                      in_dir_left_ff;
   logic                      in_dir_right_ff;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [LW-1:0]             out_level_left_ff;
   logic                      out_reverse_left_ff;
   logic [LW-1:0]             out_level_right_ff;
   logic                      out_reverse_right_ff;
   logic                      out_done_ff;

   logic                      req_fire;
   logic                      advance;
   logic                      start;

   // Stage control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign start     = (in_type_ff == wegc_pkg::REQ_START);

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   wegc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wegc_wheel #(.ENC_WIDTH(ENC_WIDTH)) u_wheel_left (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .start         (start),
      .enc           (in_enc_left_ff),
      .dir           (in_dir_left_ff),
      .target        (cfg.target_left),
      .bands         (cfg.bands),
      .max_reversals (cfg.max_reversals),
      .stat          (stat_left)
   );

   wegc_wheel #(.ENC_WIDTH(ENC_WIDTH)) u_wheel_right (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .start         (start),
      .enc           (in_enc_right_ff),
      .dir           (in_dir_right_ff),
      .target        (cfg.target_right),
      .bands         (cfg.bands),
      .max_reversals (cfg.max_reversals),
      .stat          (stat_right)
   );

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff      <= req_type;
         in_enc_left_ff  <= req_enc_left;
         in_enc_right_ff <= req_enc_right;
         in_dir_left_ff  <= req_dir_left;
         in_dir_right_ff <= req_dir_right;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_level_left_ff    <= stat_left.level;
         out_reverse_left_ff  <= stat_left.reverse;
         out_level_right_ff   <= stat_right.level;
         out_reverse_right_ff <= stat_right.reverse;
         out_done_ff          <= stat_left.idle_next && stat_right.idle_next;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_speed_level_left  = out_level_left_ff;
   assign rsp_reverse_left      = out_reverse_left_ff;
   assign rsp_speed_level_right = out_level_right_ff;
   assign rsp_reverse_right     = out_reverse_right_ff;
   assign rsp_run_done          = out_done_ff;

`ifndef ASSERT_OFF
   // Pending done flag agrees with the committed allowances
   a_done_matches: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_done_ff == (stat_left.idle_now && stat_right.idle_now))
      else $error("run_done disagrees with wheel allowances");

   // A stopped wheel is never driven backward
   a_stop_fwd_left: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_level_left_ff == wegc_pkg::LEVEL_STOP) |-> !out_reverse_left_ff)
      else $error("left wheel reversed while stopped");

   a_stop_fwd_right: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_level_right_ff == wegc_pkg::LEVEL_STOP) |-> !out_reverse_right_ff)
      else $error("right wheel reversed while stopped");

   // A stalled response keeps the input stage from draining
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("transaction advanced into a stalled result register");
`endif

endmodule

// File: test/wegc_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wegc_drive_checker
// Watches the request, response and register ports of the goto controller,
// predicts the drive command of every accepted request and compares each
// accepted response against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module wegc_drive_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  req_enc_left,
   input  logic signed [wegc_pkg::FIELD_W-1:0]  req_enc_right,
   input  logic                                 req_dir_left,
   input  logic                                 req_dir_right,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [wegc_pkg::LEVEL_W-1:0]         rsp_speed_level_left,
   input  logic                                 rsp_reverse_left,
   input  logic [wegc_pkg::LEVEL_W-1:0]         rsp_speed_level_right,
   input  logic                                 rsp_reverse_right,
   input  logic                                 rsp_run_done,
   input  logic                                 csr_wr_en,
   input  logic [wegc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wegc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   fail_count,
   output int                                   pending_count
);

   localparam int REPORT_MAX = 10;
   localparam int FW = wegc_pkg::FIELD_W;
   localparam int EW = wegc_pkg::ERR_W;
   localparam int AW = wegc_pkg::ALLOW_W;
   localparam int LW = wegc_pkg::LEVEL_W;
   localparam int BW = wegc_pkg::BAND_W;

   // One wheel's command plus its updated allowance
   typedef struct packed {
      wegc_pkg::level_type level;
      logic                reverse;
      logic [AW-1:0]       allow;
   } wheel_cmd_type;

   typedef struct packed {
      logic [LW-1:0] level_left;
      logic          reverse_left;
      logic [LW-1:0] level_right;
      logic          reverse_right;
      logic          run_done;
   } drive_cmd_type;

   wegc_pkg::cfg_type drive_cfg;
   logic [AW-1:0]     allow_left;
   logic [AW-1:0]     allow_right;
   logic [FW-1:0]     base_left;
   logic [FW-1:0]     base_right;
   drive_cmd_type     expected_cmd_q[$];

   // Band the error of one wheel and spend its allowance on arrival or reversal
   function automatic wheel_cmd_type drive_wheel(input logic [AW-1:0] allow,
                                                 input logic [FW-1:0] enc,
                                                 input logic [FW-1:0] base,
                                                 input logic signed [FW-1:0] target,
                                                 input logic dir);
      wheel_cmd_type        cmd;
      logic [FW-1:0]        pos;
      logic signed [EW-1:0] err;
      logic [EW-1:0]        mag;
      cmd.level   = wegc_pkg::LEVEL_STOP;
      cmd.reverse = 1'b0;
      cmd.allow   = allow;
      if (allow == '0) begin
         return cmd;
      end
      // wrap the position at the encoder width, then take the exact error
      pos = enc - base;
      err = $signed({{2{pos[FW-1]}}, pos}) - $signed({{2{target[FW-1]}}, target});
      mag = err[EW-1] ? -err : err;
      if (mag <= EW'(drive_cfg.bands.reached)) begin
         cmd.allow = allow - AW'(1);
         return cmd;
      end
      if (mag < EW'(drive_cfg.bands.slow)) begin
         cmd.level = wegc_pkg::LEVEL_SLOW;
      end else if (mag < EW'(drive_cfg.bands.normal)) begin
         cmd.level = wegc_pkg::LEVEL_NORMAL;
      end else if (mag < EW'(drive_cfg.bands.fast)) begin
         cmd.level = wegc_pkg::LEVEL_FAST;
      end else begin
         cmd.level = wegc_pkg::LEVEL_MAX;
      end
      cmd.reverse = !err[EW-1];
      if (cmd.reverse != dir) begin
         cmd.allow = allow - AW'(1);
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input drive_cmd_type want,
                                  input drive_cmd_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%0t: %s: expected lvl_l=%0d rev_l=%0d lvl_r=%0d rev_r=%0d done=%0d",
                  $realtime, what, want.level_left, want.reverse_left,
                  want.level_right, want.reverse_right, want.run_done);
         $display("%0t: %s:   actual lvl_l=%0d rev_l=%0d lvl_r=%0d rev_r=%0d done=%0d",
                  $realtime, what, got.level_left, got.reverse_left,
                  got.level_right, got.reverse_right, got.run_done);
      end
   endtask

   always @(posedge clock) begin : monitor
      drive_cmd_type got;
      drive_cmd_type want;
      wheel_cmd_type left;
      wheel_cmd_type right;
      if (reset) begin
         drive_cfg.target_left   = wegc_pkg::RESET_TARGET;
         drive_cfg.target_right  = wegc_pkg::RESET_TARGET;
         drive_cfg.bands.reached = wegc_pkg::RESET_REACHED_BAND;
         drive_cfg.bands.slow    = wegc_pkg::RESET_SLOW_BAND;
         drive_cfg.bands.normal  = wegc_pkg::RESET_NORMAL_BAND;
         drive_cfg.bands.fast    = wegc_pkg::RESET_FAST_BAND;
         drive_cfg.max_reversals = wegc_pkg::RESET_MAX_REVERSALS;
         allow_left  = '0;
         allow_right = '0;
         base_left   = '0;
         base_right  = '0;
         fail_count  = 0;
         expected_cmd_q.delete();
      end else begin
         // compare a taken response against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.level_left    = rsp_speed_level_left;
            got.reverse_left  = rsp_reverse_left;
            got.level_right   = rsp_speed_level_right;
            got.reverse_right = rsp_reverse_right;
            got.run_done      = rsp_run_done;
            if (expected_cmd_q.size() == 0) begin
               report_mismatch("unexpected response", '0, got);
            end else begin
               want = expected_cmd_q.pop_front();
               if (got !== want) begin
                  report_mismatch("response mismatch", want, got);
               end
            end
         end

         // track register writes
         if (csr_wr_en) begin
            case (csr_index)
               wegc_pkg::CSR_TARGET_LEFT:   drive_cfg.target_left   = csr_wdata;
               wegc_pkg::CSR_TARGET_RIGHT:  drive_cfg.target_right  = csr_wdata;
               wegc_pkg::CSR_REACHED_BAND:  drive_cfg.bands.reached = csr_wdata[BW-1:0];
               wegc_pkg::CSR_SLOW_BAND:     drive_cfg.bands.slow    = csr_wdata[BW-1:0];
               wegc_pkg::CSR_NORMAL_BAND:   drive_cfg.bands.normal  = csr_wdata[BW-1:0];
               wegc_pkg::CSR_FAST_BAND:     drive_cfg.bands.fast    = csr_wdata[BW-1:0];
               wegc_pkg::CSR_MAX_REVERSALS: drive_cfg.max_reversals = csr_wdata[AW-1:0];
               default: ;
            endcase
         end

         // predict the command for an accepted request
         if (req_valid && req_ready) begin
            if (req_type == wegc_pkg::REQ_START) begin
               base_left   = req_enc_left;
               base_right  = req_enc_right;
               allow_left  = (drive_cfg.target_left != 0) ? drive_cfg.max_reversals : '0;
               allow_right = (drive_cfg.target_right != 0) ? drive_cfg.max_reversals : '0;
            end
            left  = drive_wheel(allow_left, req_enc_left, base_left,
                                drive_cfg.target_left, req_dir_left);
            right = drive_wheel(allow_right, req_enc_right, base_right,
                                drive_cfg.target_right, req_dir_right);
            allow_left  = left.allow;
            allow_right = right.allow;
            want.level_left    = left.level;
            want.reverse_left  = left.reverse;
            want.level_right   = right.level;
            want.reverse_right = right.reverse;
            want.run_done      = (allow_left == '0) && (allow_right == '0);
            expected_cmd_q.push_back(want);
         end
      end
      pending_count = expected_cmd_q.size();
   end

endmodule

// File: test/tb_wheel_encoder_goto_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wheel_encoder_goto_controller_core
// Drives directed and random goto runs into the controller under random
// request gaps and response stalls, rewrites the settings between phases
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_wheel_encoder_goto_controller_core;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 7;
   localparam int ITEM_TOTAL   = 1950;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 150;
   localparam int FW = wegc_pkg::FIELD_W;
   localparam int LW = wegc_pkg::LEVEL_W;
   localparam int IW = wegc_pkg::CSR_IDX_W;
   localparam int DW = wegc_pkg::CSR_DATA_W;
   localparam int BW = wegc_pkg::BAND_W;
   localparam int AW = wegc_pkg::ALLOW_W;
   localparam logic [IW-1:0] CSR_IDX_SPARE = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_type = wegc_pkg::REQ_TICK;
   logic [FW-1:0]     req_enc_left = '0;
   logic [FW-1:0]     req_enc_right = '0;
   logic              req_dir_left = 1'b0;
   logic              req_dir_right = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [LW-1:0]     rsp_speed_level_left;
   logic              rsp_reverse_left;
   logic [LW-1:0]     rsp_speed_level_right;
   logic              rsp_reverse_right;
   logic              rsp_run_done;
   logic              csr_wr_en = 1'b0;
   logic [IW-1:0]     csr_index = '0;
   logic [DW-1:0]     csr_wdata = '0;

   int fail_count;
   int pending_count;
   int items_sent = 0;
   int sender_mode = 0;
   int receiver_mode = 1;
   int hold_left = 0;
   bit long_hold_due = 1'b0;
   int idle_cycles = 0;
   int target_left = 0;
   int target_right = 0;

   wheel_encoder_goto_controller_core uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_enc_left          (req_enc_left),
      .req_enc_right         (req_enc_right),
      .req_dir_left          (req_dir_left),
      .req_dir_right         (req_dir_right),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_speed_level_left  (rsp_speed_level_left),
      .rsp_reverse_left      (rsp_reverse_left),
      .rsp_speed_level_right (rsp_speed_level_right),
      .rsp_reverse_right     (rsp_reverse_right),
      .rsp_run_done          (rsp_run_done),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   wegc_drive_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_enc_left          (req_enc_left),
      .req_enc_right         (req_enc_right),
      .req_dir_left          (req_dir_left),
      .req_dir_right         (req_dir_right),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_speed_level_left  (rsp_speed_level_left),
      .rsp_reverse_left      (rsp_reverse_left),
      .rsp_speed_level_right (rsp_speed_level_right),
      .rsp_reverse_right     (rsp_reverse_right),
      .rsp_run_done          (rsp_run_done),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .fail_count            (fail_count),
      .pending_count         (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Mostly short gaps, a few long ones; mode zero means no idling at all
   function automatic int pick_gap(input int mode);
      int r;
      if (mode == 0) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offer one transaction and hold it until it is taken
   task automatic send_item(input logic kind, input logic [FW-1:0] enc_l,
                            input logic [FW-1:0] enc_r, input logic dir_l,
                            input logic dir_r);
      int gap;
      gap = pick_gap(sender_mode);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_enc_left  <= enc_l;
      req_enc_right <= enc_r;
      req_dir_left  <= dir_l;
      req_dir_right <= dir_r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and wait until every response is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_target();
      logic signed [FW-1:0] v;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 0;
      end else if (r == 1) begin
         return $urandom_range(0, 1) ? 32767 : -32768;
      end else if (r == 2) begin
         v = FW'($urandom);
         return v;
      end
      v = FW'($urandom_range(1, 400));
      return $urandom_range(0, 1) ? v : -v;
   endfunction

   // New targets, bands and allowance for a phase
   task automatic configure_random();
      logic [BW-1:0] reached, slow, normal, fast;
      logic [AW-1:0] reversals;
      int r;
      target_left  = pick_target();
      target_right = pick_target();
      r = $urandom_range(0, 5);
      if (r == 0) begin
         reached = BW'($urandom);
         slow    = BW'($urandom);
         normal  = BW'($urandom);
         fast    = BW'($urandom);
      end else if (r == 1) begin
         reached = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         slow    = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         normal  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         fast    = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end else begin
         reached = BW'($urandom_range(0, 5));
         slow    = reached + BW'($urandom_range(1, 6));
         normal  = slow + BW'($urandom_range(1, 20));
         fast    = normal + BW'($urandom_range(1, 60));
      end
      r = $urandom_range(0, 9);
      reversals = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(1, 15));
      write_reg(wegc_pkg::CSR_TARGET_LEFT, target_left[FW-1:0]);
      write_reg(wegc_pkg::CSR_TARGET_RIGHT, target_right[FW-1:0]);
      write_reg(wegc_pkg::CSR_REACHED_BAND, {8'($urandom), reached});
      write_reg(wegc_pkg::CSR_SLOW_BAND, {8'($urandom), slow});
      write_reg(wegc_pkg::CSR_NORMAL_BAND, {8'($urandom), normal});
      write_reg(wegc_pkg::CSR_FAST_BAND, {8'($urandom), fast});
      write_reg(wegc_pkg::CSR_MAX_REVERSALS, {12'($urandom), reversals});
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_IDX_SPARE, 16'($urandom));
      end
   endtask

   // Move a wheel toward its target, now and then overshooting
   function automatic int next_pos(input int pos, input int target);
      int gap, span, sgn;
      gap  = target - pos;
      sgn  = (gap < 0) ? -1 : 1;
      span = (gap < 0) ? -gap : gap;
      if (span == 0) begin
         return pos + int'($urandom_range(0, 6)) - 3;
      end
      if ($urandom_range(0, 7) == 0) begin
         return pos + sgn * (span + int'($urandom_range(1, 30)));
      end
      return pos + sgn * int'($urandom_range(0, span / 3 + 2));
   endfunction

   // One start transaction followed by ticks of a plausible drive
   task automatic run_goto(input int n_ticks);
      logic [FW-1:0] base_l, base_r, enc_l, enc_r;
      logic dir_l, dir_r;
      int pos_l, pos_r, k;
      base_l = FW'($urandom);
      base_r = FW'($urandom);
      pos_l  = 0;
      pos_r  = 0;
      send_item(wegc_pkg::REQ_START, base_l, base_r,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (k = 0; k < n_ticks; k++) begin
         pos_l = next_pos(pos_l, target_left);
         pos_r = next_pos(pos_r, target_right);
         enc_l = FW'(int'(base_l) + pos_l);
         enc_r = FW'(int'(base_r) + pos_r);
         dir_l = (pos_l > target_left) ^ ($urandom_range(0, 9) == 0);
         dir_r = (pos_r > target_right) ^ ($urandom_range(0, 9) == 0);
         send_item(wegc_pkg::REQ_TICK, enc_l, enc_r, dir_l, dir_r);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int gap;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            gap = pick_gap(receiver_mode);
            if (receiver_mode != 0 && $urandom_range(0, 199) == 0) begin
               gap = $urandom_range(40, 120);
            end
            if (gap == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold_left = gap - 1;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_wheel_encoder_goto_controller_core: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase, phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ticks with no run under way, encoder extremes
      send_item(wegc_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_item(wegc_pkg::REQ_TICK, 16'h7FFF, 16'h8000, 1'b1, 1'b1);

      // walk both wheels through every speed band; right wraps below -32768
      settle();
      write_reg(wegc_pkg::CSR_TARGET_LEFT, 16'd100);
      write_reg(wegc_pkg::CSR_TARGET_RIGHT, 16'hFF9C);
      send_item(wegc_pkg::REQ_START, 16'd1000, 16'h8000, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd1060, 16'h7FD8, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd1075, 16'h7FB5, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd1092, 16'h7FA4, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd1097, 16'h7F9F, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd1098, 16'h7F9E, 1'b0, 1'b1);
      // overshoot against the reported direction
      send_item(wegc_pkg::REQ_TICK, 16'd1110, 16'h7F90, 1'b0, 1'b1);

      // extreme targets and the largest error magnitudes
      settle();
      write_reg(wegc_pkg::CSR_MAX_REVERSALS, 16'd15);
      write_reg(wegc_pkg::CSR_TARGET_LEFT, 16'h7FFF);
      write_reg(wegc_pkg::CSR_TARGET_RIGHT, 16'h8000);
      send_item(wegc_pkg::REQ_START, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'h8000, 16'h7FFF, 1'b1, 1'b0);

      // zero allowance keeps both wheels inactive
      settle();
      write_reg(wegc_pkg::CSR_MAX_REVERSALS, 16'd0);
      send_item(wegc_pkg::REQ_START, 16'h1234, 16'hFEDC, 1'b0, 1'b0);
      send_item(wegc_pkg::REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1);

      // bands out of order: slow wins over normal and fast
      settle();
      write_reg(wegc_pkg::CSR_MAX_REVERSALS, 16'd4);
      write_reg(wegc_pkg::CSR_REACHED_BAND, 16'd0);
      write_reg(wegc_pkg::CSR_SLOW_BAND, 16'd255);
      write_reg(wegc_pkg::CSR_NORMAL_BAND, 16'd3);
      write_reg(wegc_pkg::CSR_FAST_BAND, 16'd1);
      write_reg(wegc_pkg::CSR_TARGET_LEFT, 16'd5);
      write_reg(wegc_pkg::CSR_TARGET_RIGHT, 16'hFFFB);
      send_item(wegc_pkg::REQ_START, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd5, 16'hFFFB, 1'b0, 1'b1);
      send_item(wegc_pkg::REQ_TICK, 16'd6, 16'hFFFA, 1'b1, 1'b0);

      // widest arrival band, then everything else at zero
      settle();
      write_reg(wegc_pkg::CSR_REACHED_BAND, 16'd255);
      write_reg(wegc_pkg::CSR_SLOW_BAND, 16'd0);
      write_reg(wegc_pkg::CSR_NORMAL_BAND, 16'd0);
      write_reg(wegc_pkg::CSR_FAST_BAND, 16'd0);
      send_item(wegc_pkg::REQ_START, 16'h4000, 16'hC000, 1'b0, 1'b0);
      send_item(wegc_pkg::REQ_TICK, 16'h43E8, 16'hBC18, 1'b0, 1'b1);

      // write to an unused index must not disturb anything
      settle();
      write_reg(CSR_IDX_SPARE, 16'hFFFF);
      send_item(wegc_pkg::REQ_START, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_item(wegc_pkg::REQ_TICK, 16'h0100, 16'hFF00, 1'b1, 1'b0);

      // random phases: new settings, then goto runs mixed with noise
      phase = 0;
      while (items_sent < ITEM_TOTAL) begin
         settle();
         configure_random();
         if (phase == 0) begin
            // hold the receiver off while requests keep coming
            sender_mode   = 0;
            receiver_mode = 1;
            long_hold_due = 1'b1;
         end else begin
            sender_mode   = ($urandom_range(0, 2) == 0) ? 0 : 1;
            receiver_mode = ($urandom_range(0, 2) == 0) ? 0 : 1;
         end
         phase_end = items_sent + $urandom_range(30, 70);
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 6) == 0) begin
               send_item(($urandom_range(0, 3) == 0) ? wegc_pkg::REQ_START
                                                     : wegc_pkg::REQ_TICK,
                         16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               run_goto($urandom_range(3, 30));
            end
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_wheel_encoder_goto_controller_core: PASS");
      end else begin
         $display("tb_wheel_encoder_goto_controller_core: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/wegc_pkg.sv
hdl/wegc_csr.sv
hdl/wegc_wheel.sv
hdl/wheel_encoder_goto_controller_core.sv
test/wegc_drive_checker.sv
test/tb_wheel_encoder_goto_controller_core.sv
